// ===== sv/stable_min_priority_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the run queue
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STABLE_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define SMPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run queue assertion failed");

// next-cycle implication
`define SMPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run queue assertion failed");

`endif

// ===== sv/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and codes shared by the run queue modules.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_HANDLE_BITS = 16;

    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 16;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                cmd;
        logic [KEY_W-1:0]    pass_key;
        logic [HANDLE_W-1:0] thread_handle;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] removed_handle;
        logic [KEY_W-1:0]    removed_key;
        logic [OCC_W-1:0]    occupancy;
    } out_word_t;

endpackage

// ===== sv/stable_min_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue_unit
// Run queue ordered by pass key, first-in first-out among equal keys.
// ----------------------------------------------------------------------------
//  channel | signals                      | word
//  in      | in_valid, in_stall, in_data  | cmd, pass_key, thread_handle
//  out     | out_valid, out_stall, out_data | status, handle, key, occupancy
//
//  Insert, full insert and empty remove: result word valid the cycle after
//  the input word is taken. A remove scans the held entries for the minimum
//  (S_SCAN), lands the last compare (S_SCAN_END), moves each entry above
//  the minimum down one slot (S_SHIFT) and posts the word (S_DONE), with one
//  read and one write of the entry RAM a cycle. No clearing pass after reset.
//  in_stall is high while a remove is at work or a finished word is stalled.
// ----------------------------------------------------------------------------
`include "stable_min_priority_queue_unit_assert.svh"

module stable_min_priority_queue_unit #(
    parameter int CAPACITY    = smpq_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = smpq_pkg::DEF_HANDLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  smpq_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output smpq_pkg::out_word_t out_data
);

    import smpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int DW = KEY_W + HANDLE_BITS;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SCAN_END = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]          best_idx_reg, best_idx_next;
    logic [KEY_W-1:0]       best_key_reg, best_key_next;
    logic [HANDLE_BITS-1:0] best_handle_reg, best_handle_next;
    logic [CW-1:0]          src_reg, src_next;
    logic [CW-1:0]          dst_reg, dst_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_word_reg, out_word_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [DW-1:0]          ram_wdata, ram_rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic                   out_free, in_take;

    assign rd_key    = ram_rdata[DW-1:HANDLE_BITS];
    assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    smpq_ram #(
        .WIDTH(DW),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // running minimum; strict less keeps the oldest among equal keys
    always_comb
    begin
        best_idx_next    = best_idx_reg;
        best_key_next    = best_key_reg;
        best_handle_next = best_handle_reg;
        if (cmp_valid_reg && ((cmp_idx_reg == '0) || (rd_key < best_key_reg)))
        begin
            best_idx_next    = cmp_idx_reg;
            best_key_next    = rd_key;
            best_handle_next = rd_handle;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = {in_data.pass_key,
                          HANDLE_BITS'(in_data.thread_handle[SW-1:0])};
        ram_raddr      = scan_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    out_word_next.removed_handle = '0;
                    out_word_next.removed_key    = '0;
                    out_word_next.occupancy      = OCC_W'(count_reg);
                    if (in_data.cmd == CMD_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            out_word_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_we                  = 1'b1;
                            count_next              = count_reg + CW'(1);
                            out_word_next.status    = ST_INSERTED;
                            out_word_next.occupancy = OCC_W'(count_reg + CW'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next       = 1'b1;
                        out_word_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ram_raddr      = scan_reg[AW-1:0];
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_reg;
                scan_next      = scan_reg + CW'(1);
                if (scan_reg == count_reg - CW'(1))
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                // last compare lands this cycle
                src_next   = best_idx_next + CW'(1);
                pend_next  = 1'b0;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                ram_raddr = src_reg[AW-1:0];
                ram_waddr = dst_reg[AW-1:0];
                ram_wdata = ram_rdata;
                ram_we    = pend_reg;
                if (src_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    dst_next  = src_reg - CW'(1);
                    src_next  = src_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.status         = ST_REMOVED;
                    out_word_next.removed_handle = HANDLE_W'(best_handle_reg);
                    out_word_next.removed_key    = best_key_reg;
                    out_word_next.occupancy      = OCC_W'(count_reg - CW'(1));
                    count_next                   = count_reg - CW'(1);
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg        <= scan_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_key_reg    <= best_key_next;
        best_handle_reg <= best_handle_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        out_word_reg    <= out_word_next;
    end

    `SMPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `SMPQ_ASSERT_NOW(a_busy_stalls, state_reg != S_IDLE, in_stall)
    `SMPQ_ASSERT_NEXT(a_insert_grows,
        in_take && (in_data.cmd == CMD_INSERT) && (count_reg < CW'(CAPACITY)),
        count_reg == $past(count_reg) + CW'(1))
    `SMPQ_ASSERT_NOW(a_shift_in_range, (state_reg == S_SHIFT) && ram_we,
        dst_reg < count_reg)

endmodule

// ===== sv/smpq_ram.sv =====
// ----------------------------------------------------------------------------
// smpq_ram
// Generic RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sim/smpq_checker.sv =====
// ----------------------------------------------------------------------------
// smpq_checker
// Watches both channels of the run queue, predicts each result word from its
// own copy of the queue and compares field by field.
// ----------------------------------------------------------------------------
module smpq_checker #(
    parameter int CAPACITY    = smpq_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = smpq_pkg::DEF_HANDLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  smpq_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  smpq_pkg::out_word_t out_data,
    output int                  fail_count,
    output int                  pending
);
    import smpq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [KEY_W-1:0]    q_keys[$];
    logic [HANDLE_W-1:0] q_handles[$];
    out_word_t           expected_words[$];

    assign pending = expected_words.size();

    function automatic out_word_t apply_cmd(in_word_t w);
        out_word_t r;
        int best;
        r = '0;
        if (w.cmd == CMD_INSERT)
        begin
            if (q_keys.size() >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                q_keys.push_back(w.pass_key);
                q_handles.push_back(HANDLE_W'(w.thread_handle & ((1 << HANDLE_BITS) - 1)));
                r.status = ST_INSERTED;
            end
        end
        else if (q_keys.size() == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            best = 0;
            // strict less keeps the oldest among equal keys
            for (int i = 1; i < q_keys.size(); i++)
                if (q_keys[i] < q_keys[best])
                    best = i;
            r.status = ST_REMOVED;
            r.removed_handle = q_handles[best];
            r.removed_key = q_keys[best];
            q_keys.delete(best);
            q_handles.delete(best);
        end
        r.occupancy = OCC_W'(q_keys.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            q_keys.delete();
            q_handles.delete();
            expected_words.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_words.push_back(apply_cmd(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected word %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e.status !== out_data.status
                        || e.removed_handle !== out_data.removed_handle
                        || e.removed_key !== out_data.removed_key
                        || e.occupancy !== out_data.occupancy)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: expected st=%0d h=%h k=%h occ=%0d,",
                                      " got st=%0d h=%h k=%h occ=%0d"},
                                     e.status, e.removed_handle, e.removed_key,
                                     e.occupancy, out_data.status,
                                     out_data.removed_handle,
                                     out_data.removed_key, out_data.occupancy);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb_stable_min_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_stable_min_priority_queue_unit
// Drives directed and random insert/remove words into the run queue with
// random idling on both sides; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_stable_min_priority_queue_unit;
    import smpq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1305;
    localparam int WD_LIMIT  = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;
    int        fail_count;
    int        pending;
    bit        calm;
    int        idle_cycles;
    int        key_mode;

    stable_min_priority_queue_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    smpq_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(negedge clk);
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return KEY_W'($urandom_range(0, 3));
            2: return {32'hFFFFFFFF, 28'hFFFFFFF, 4'($urandom_range(0, 15))};
            default: return {32'h0, 24'h0, 8'($urandom_range(0, 255))};
        endcase
    endfunction

    task automatic send_word(logic c, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
        in_data  <= '{cmd: c, pass_key: k, thread_handle: h};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    task automatic send_random(int n_ins_weight);
        logic [HANDLE_W-1:0] h;
        h = HANDLE_W'($urandom);
        if ($urandom_range(0, 99) < n_ins_weight)
            send_word(CMD_INSERT, pick_key(), h);
        else
            send_word(CMD_REMOVE, {$urandom, $urandom}, h);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        calm     = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty remove, extremes, equal keys order
        send_word(CMD_REMOVE, '1, '1);
        send_word(CMD_INSERT, '1, 16'hFFFF);
        send_word(CMD_INSERT, '0, 16'h0000);
        send_word(CMD_INSERT, 64'd5, 16'h1111);
        send_word(CMD_INSERT, 64'd5, 16'h2222);
        send_word(CMD_INSERT, 64'd5, 16'h3333);
        send_word(CMD_INSERT, '0, 16'hA5A5);
        repeat (7) send_word(CMD_REMOVE, '1, '1);
        // fill to capacity and overflow
        for (int i = 0; i < DEF_CAPACITY + 2; i++)
            send_word(CMD_INSERT, 64'($urandom_range(0, 7)), 16'(i));

        // hold off until everything is back
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // phases drift the occupancy between empty and full
            key_mode = (i / 150) % 3;
            if (i > N_RANDOM - 150)
                calm = 1'b1;
            send_random(key_mode == 0 ? 75 : (key_mode == 1 ? 50 : 25));
        end
        for (int i = 0; i < DEF_CAPACITY + 1; i++)
            send_word(CMD_REMOVE, '0, '0);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/smpq_pkg.sv
sv/smpq_ram.sv
sv/stable_min_priority_queue_unit.sv
sim/smpq_checker.sv
sim/tb_stable_min_priority_queue_unit.sv
